>>> rtl/core/bswr_pkg.sv
// shared types and constants for the byte stack with rotate
package bswr_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int CW    = 7;
  localparam int DW    = 8;
  localparam int MW    = 3;

  typedef enum logic [MW-1:0] {
    MODE_PUSH     = 3'd0,
    MODE_POP      = 3'd1,
    MODE_PEEK     = 3'd2,
    MODE_DUP      = 3'd3,
    MODE_ROT_UP   = 3'd4,
    MODE_ROT_DOWN = 3'd5,
    MODE_PRINT    = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_ITEM  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    status_t         status;
    logic [DW-1:0]   item;
    logic            last;
  } result_t;

  typedef struct packed {
    logic            we;
    logic [AW-1:0]   waddr;
    logic [DW-1:0]   wdata;
    logic [AW-1:0]   raddr;
  } ram_req_t;

endpackage

>>> rtl/core/bswr_ram.sv
// simple dual-port ram, one write and one registered read per cycle
module bswr_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/bswr_seq.sv
// command sequencer: fill level, capacity and read-modify-write walks over the ram
module bswr_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [bswr_pkg::MW-1:0]      mode,
  input  logic [bswr_pkg::DW-1:0]      value,
  input  logic [bswr_pkg::CW-1:0]      count,
  input  logic                         cfg_we,
  input  logic [bswr_pkg::CW-1:0]      capacity,
  input  logic                         out_free,
  input  logic [bswr_pkg::DW-1:0]      rdata,
  output logic                         idle,
  output logic                         emit,
  output bswr_pkg::result_t            res,
  output bswr_pkg::ram_req_t           ram
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_CMD       = 8'b0000_0010,
    S_RD        = 8'b0000_0100,
    S_PRINT     = 8'b0000_1000,
    S_ROT_TMP   = 8'b0001_0000,
    S_ROT_SHIFT = 8'b0010_0000,
    S_ROT_LAST  = 8'b0100_0000,
    S_FIN       = 8'b1000_0000
  } state_t;

  state_t                      state, state_next;
  logic [bswr_pkg::FW-1:0]     fill, fill_next;
  logic [bswr_pkg::FW-1:0]     cap;
  bswr_pkg::mode_t             cmd_mode;
  logic [bswr_pkg::DW-1:0]     cmd_value;
  logic [bswr_pkg::CW-1:0]     cmd_count;
  logic [bswr_pkg::AW-1:0]     ptr, ptr_next;
  logic [bswr_pkg::AW-1:0]     stop, stop_next;
  logic [bswr_pkg::DW-1:0]     tmp, tmp_next;

  logic                        full, empty, cnt_ok, rot_down;
  logic [bswr_pkg::AW-1:0]     top_addr, base_addr, step1, step2;

  assign idle     = (state == S_IDLE);
  assign full     = (fill >= cap);
  assign empty    = (fill == '0);
  assign cnt_ok   = (cmd_count > bswr_pkg::CW'(1)) && (cmd_count <= bswr_pkg::CW'(fill));
  assign top_addr = bswr_pkg::AW'(fill - bswr_pkg::FW'(1));
  assign base_addr = bswr_pkg::AW'(fill - bswr_pkg::FW'(cmd_count));
  assign rot_down = (cmd_mode == bswr_pkg::MODE_ROT_DOWN);
  // walk direction: rotate up moves toward the bottom, rotate down toward the top
  assign step1    = rot_down ? ptr + bswr_pkg::AW'(1) : ptr - bswr_pkg::AW'(1);
  assign step2    = rot_down ? ptr + bswr_pkg::AW'(2) : ptr - bswr_pkg::AW'(2);

  always_comb begin
    state_next = state;
    fill_next  = fill;
    ptr_next   = ptr;
    stop_next  = stop;
    tmp_next   = tmp;
    emit       = 1'b0;
    res.status = bswr_pkg::ST_DONE;
    res.item   = '0;
    res.last   = 1'b1;
    ram.we     = 1'b0;
    ram.waddr  = fill[bswr_pkg::AW-1:0];
    ram.wdata  = cmd_value;
    ram.raddr  = top_addr;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMD;
        end
      end

      S_CMD: begin
        unique case (cmd_mode)
          bswr_pkg::MODE_PUSH: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (full) begin
                res.status = bswr_pkg::ST_FULL;
              end else begin
                ram.we    = 1'b1;
                fill_next = fill + bswr_pkg::FW'(1);
              end
            end
          end
          bswr_pkg::MODE_POP, bswr_pkg::MODE_PEEK: begin
            if (!empty) begin
              state_next = S_RD;
            end else if (out_free) begin
              emit       = 1'b1;
              res.status = bswr_pkg::ST_EMPTY;
              state_next = S_IDLE;
            end
          end
          bswr_pkg::MODE_DUP: begin
            if (!empty && !full) begin
              state_next = S_RD;
            end else if (out_free) begin
              emit       = 1'b1;
              res.status = empty ? bswr_pkg::ST_EMPTY : bswr_pkg::ST_FULL;
              state_next = S_IDLE;
            end
          end
          bswr_pkg::MODE_ROT_UP, bswr_pkg::MODE_ROT_DOWN: begin
            if (cnt_ok) begin
              // the walk starts at the entry that moves out of the way
              ram.raddr  = rot_down ? base_addr : top_addr;
              ptr_next   = rot_down ? base_addr : top_addr;
              stop_next  = rot_down ? top_addr : base_addr;
              state_next = S_ROT_TMP;
            end else if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end
          end
          bswr_pkg::MODE_PRINT: begin
            if (!empty) begin
              ptr_next   = top_addr;
              state_next = S_PRINT;
            end else if (out_free) begin
              emit       = 1'b1;
              res.status = bswr_pkg::ST_EMPTY;
              state_next = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end

      S_RD: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (cmd_mode == bswr_pkg::MODE_DUP) begin
            ram.we    = 1'b1;
            ram.wdata = rdata;
            fill_next = fill + bswr_pkg::FW'(1);
          end else begin
            res.status = bswr_pkg::ST_ITEM;
            res.item   = rdata;
            if (cmd_mode == bswr_pkg::MODE_POP) begin
              fill_next = fill - bswr_pkg::FW'(1);
            end
          end
        end
      end

      S_PRINT: begin
        // hold the read address while the output is blocked
        ram.raddr = out_free ? ptr - bswr_pkg::AW'(1) : ptr;
        if (out_free) begin
          emit       = 1'b1;
          res.status = bswr_pkg::ST_ITEM;
          res.item   = rdata;
          res.last   = (ptr == '0);
          if (ptr == '0) begin
            state_next = S_IDLE;
          end else begin
            ptr_next = ptr - bswr_pkg::AW'(1);
          end
        end
      end

      S_ROT_TMP: begin
        tmp_next   = rdata;
        ram.raddr  = step1;
        state_next = S_ROT_SHIFT;
      end

      S_ROT_SHIFT: begin
        // write one entry, read the next one two places ahead of the write
        ram.we    = 1'b1;
        ram.waddr = ptr;
        ram.wdata = rdata;
        ram.raddr = step2;
        ptr_next  = step1;
        if (step1 == stop) begin
          state_next = S_ROT_LAST;
        end
      end

      S_ROT_LAST: begin
        ram.we     = 1'b1;
        ram.waddr  = ptr;
        ram.wdata  = tmp;
        state_next = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      cap   <= bswr_pkg::FW'(bswr_pkg::DEPTH);
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_we) begin
        if (capacity == '0) begin
          cap <= bswr_pkg::FW'(1);
        end else if (capacity > bswr_pkg::CW'(bswr_pkg::DEPTH)) begin
          cap <= bswr_pkg::FW'(bswr_pkg::DEPTH);
        end else begin
          cap <= bswr_pkg::FW'(capacity);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    stop <= stop_next;
    tmp  <= tmp_next;
    if (idle && in_valid) begin
      cmd_mode  <= bswr_pkg::mode_t'(mode);
      cmd_value <= value;
      cmd_count <= count;
    end
  end

endmodule

>>> rtl/core/byte_stack_with_rotate.sv
// Byte stack with rotate: a last-in first-out store of up to 64 bytes held in one
// synchronous ram with a registered read, with a capacity register written over
// its own port (0 acts as 1, values above 64 act as 64). One command is taken at a time;
// in_stall stays high until the command's last result beat has been loaded into the
// output register. Push and the single-result cases that need no read answer from S_CMD;
// pop, peek and dup make one ram read, print reads all f entries from the top, and a
// rotation over n entries shifts them with one ram write per cycle. A stalled output
// holds back the next result beat. The ram needs no clearing after reset.
module byte_stack_with_rotate (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [bswr_pkg::MW-1:0]  mode,
  input  logic [bswr_pkg::DW-1:0]  value,
  input  logic [bswr_pkg::CW-1:0]  count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [bswr_pkg::CW-1:0]  capacity,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic [bswr_pkg::DW-1:0]  item,
  output logic                     last
);

  logic                      idle, emit, out_free;
  bswr_pkg::result_t         res, out_q;
  bswr_pkg::ram_req_t        ram;
  logic [bswr_pkg::DW-1:0]   rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle;
  assign out_free  = !out_valid || !out_stall;

  bswr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .value    (value),
    .count    (count),
    .cfg_we   (cfg_valid && cfg_ready),
    .capacity (capacity),
    .out_free (out_free),
    .rdata    (rdata),
    .idle     (idle),
    .emit     (emit),
    .res      (res),
    .ram      (ram)
  );

  bswr_ram #(
    .AW (bswr_pkg::AW),
    .DW (bswr_pkg::DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  // output register: emit is only raised when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign status = out_q.status;
  assign item   = out_q.item;
  assign last   = out_q.last;

endmodule

>>> rtl/core/bswr_chk.sv
// port-level checks for the byte stack with rotate, bound to the top level
module bswr_chk (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               status,
  input logic [bswr_pkg::DW-1:0]  item,
  input logic                     last
);

  // one command at a time: an accepted beat closes the input
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a command was in flight");

  // a non-final beat on the output means the burst is still being walked
  a_burst_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input opened in the middle of a result burst");

  // only returned items come in bursts and carry data
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bswr_pkg::ST_ITEM |-> last && item == '0)
    else $error("non-item result is not a single final beat with zero data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(item) && $stable(last))
    else $error("stalled result beat changed");

endmodule

bind byte_stack_with_rotate bswr_chk u_bswr_chk (.*);

>>> tb/byte_stack_with_rotate_checker.sv
// channel monitor, stack predictor and result comparison for the byte stack with rotate
`timescale 1ns / 100ps

module byte_stack_with_rotate_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [bswr_pkg::MW-1:0]  mode,
  input  logic [bswr_pkg::DW-1:0]  value,
  input  logic [bswr_pkg::CW-1:0]  count,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [bswr_pkg::CW-1:0]  capacity,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [1:0]               status,
  input  logic [bswr_pkg::DW-1:0]  item,
  input  logic                     last,
  output int                       errors,
  output int                       expected_left
);

  logic [bswr_pkg::DW-1:0] stack_copy [bswr_pkg::DEPTH];
  int                      fill_copy;
  logic [bswr_pkg::CW-1:0] capacity_reg;
  bswr_pkg::result_t       due_results [$];

  function automatic int usable_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > bswr_pkg::DEPTH) return bswr_pkg::DEPTH;
    return int'(capacity_reg);
  endfunction

  function automatic void queue_result(bswr_pkg::status_t s, logic [bswr_pkg::DW-1:0] b,
                                       logic l);
    bswr_pkg::result_t r;
    r.status = s;
    r.item   = b;
    r.last   = l;
    due_results.push_back(r);
  endfunction

  function automatic void apply_command(logic [bswr_pkg::MW-1:0] m,
                                        logic [bswr_pkg::DW-1:0] v,
                                        logic [bswr_pkg::CW-1:0] n);
    int                      f;
    int                      lim;
    int                      base;
    int                      i;
    logic [bswr_pkg::DW-1:0] held;
    f   = fill_copy;
    lim = usable_capacity();
    case (m)
      bswr_pkg::MODE_PUSH: begin
        if (f >= lim) begin
          queue_result(bswr_pkg::ST_FULL, '0, 1'b1);
        end else begin
          stack_copy[bswr_pkg::AW'(f)] = v;
          fill_copy = f + 1;
          queue_result(bswr_pkg::ST_DONE, '0, 1'b1);
        end
      end
      bswr_pkg::MODE_POP, bswr_pkg::MODE_PEEK: begin
        if (f == 0) begin
          queue_result(bswr_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          queue_result(bswr_pkg::ST_ITEM, stack_copy[bswr_pkg::AW'(f-1)], 1'b1);
          if (m == bswr_pkg::MODE_POP) fill_copy = f - 1;
        end
      end
      bswr_pkg::MODE_DUP: begin
        if (f == 0) begin
          queue_result(bswr_pkg::ST_EMPTY, '0, 1'b1);
        end else if (f >= lim) begin
          queue_result(bswr_pkg::ST_FULL, '0, 1'b1);
        end else begin
          stack_copy[bswr_pkg::AW'(f)] = stack_copy[bswr_pkg::AW'(f-1)];
          fill_copy = f + 1;
          queue_result(bswr_pkg::ST_DONE, '0, 1'b1);
        end
      end
      bswr_pkg::MODE_ROT_UP: begin
        // top entry sinks to depth n, the entries that were above that depth rise by one
        if (n != 0 && n <= f) begin
          base = f - n;
          held = stack_copy[bswr_pkg::AW'(f-1)];
          for (i = f - 1; i > base; i--)
            stack_copy[bswr_pkg::AW'(i)] = stack_copy[bswr_pkg::AW'(i-1)];
          stack_copy[bswr_pkg::AW'(base)] = held;
        end
        queue_result(bswr_pkg::ST_DONE, '0, 1'b1);
      end
      bswr_pkg::MODE_ROT_DOWN: begin
        if (n != 0 && n <= f) begin
          base = f - n;
          held = stack_copy[bswr_pkg::AW'(base)];
          for (i = base; i + 1 < f; i++)
            stack_copy[bswr_pkg::AW'(i)] = stack_copy[bswr_pkg::AW'(i+1)];
          stack_copy[bswr_pkg::AW'(f-1)] = held;
        end
        queue_result(bswr_pkg::ST_DONE, '0, 1'b1);
      end
      bswr_pkg::MODE_PRINT: begin
        if (f == 0) begin
          queue_result(bswr_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = f; i > 0; i--)
            queue_result(bswr_pkg::ST_ITEM, stack_copy[bswr_pkg::AW'(i-1)], i == 1);
        end
      end
      default: queue_result(bswr_pkg::ST_DONE, '0, 1'b1);
    endcase
  endfunction

  task automatic compare_beat();
    bswr_pkg::result_t want;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: unexpected result beat status %0d item %02h last %0d",
                 status, item, last);
    end else begin
      want = due_results.pop_front();
      if (want.status !== status || want.item !== item || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d item %02h last %0d, got %0d %02h %0d",
                   want.status, want.item, want.last, status, item, last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill_copy = 0;
      capacity_reg = 7'd64;
      due_results.delete();
    end else begin
      // drain before predicting, the new command's beats come later
      if (out_valid && !out_stall) compare_beat();
      if (cfg_valid && cfg_ready) capacity_reg = capacity;
      if (in_valid && !in_stall) apply_command(mode, value, count);
    end
    expected_left = due_results.size();
  end

endmodule

>>> tb/byte_stack_with_rotate_test.sv
// stimulus, clock, reset and verdict for the byte stack with rotate
`timescale 1ns / 100ps

module byte_stack_with_rotate_test;

  localparam logic [bswr_pkg::MW-1:0] MODE_UNUSED = 3'd7;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [bswr_pkg::MW-1:0] mode;
  logic [bswr_pkg::DW-1:0] value;
  logic [bswr_pkg::CW-1:0] count;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [bswr_pkg::CW-1:0] capacity;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              status;
  logic [bswr_pkg::DW-1:0] item;
  logic                    last;
  int                      errors;
  int                      expected_left;
  bit                      calm;
  int                      hold_requests;

  byte_stack_with_rotate u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .value     (value),
    .count     (count),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .capacity  (capacity),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .item      (item),
    .last      (last)
  );

  byte_stack_with_rotate_checker u_checker (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // output side: random stall, calm stretches and one long hold-off
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 34);
      end
    end
  end

  // called at a rising edge, returns at the edge that takes the beat
  task automatic send_cmd(input logic [bswr_pkg::MW-1:0] m, input logic [bswr_pkg::DW-1:0] v,
                          input logic [bswr_pkg::CW-1:0] n);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    count    <= n;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [bswr_pkg::CW-1:0] c);
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    capacity  <= c;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int items, input int push_pct);
    logic [bswr_pkg::MW-1:0] m;
    logic [bswr_pkg::CW-1:0] n;
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(99) < push_pct) begin
        m = bswr_pkg::MODE_PUSH;
      end else begin
        case ($urandom_range(12))
          2:       m = bswr_pkg::MODE_PEEK;
          3, 4:    m = bswr_pkg::MODE_DUP;
          5, 6:    m = bswr_pkg::MODE_ROT_UP;
          7, 8:    m = bswr_pkg::MODE_ROT_DOWN;
          9:       m = bswr_pkg::MODE_PRINT;
          10:      m = MODE_UNUSED;
          default: m = bswr_pkg::MODE_POP;
        endcase
      end
      case ($urandom_range(9))
        0:       n = '0;
        1:       n = bswr_pkg::CW'($urandom_range(65, 127));
        2, 3:    n = bswr_pkg::CW'($urandom_range(1, 64));
        default: n = bswr_pkg::CW'($urandom_range(1, 8));
      endcase
      send_cmd(m, bswr_pkg::DW'($urandom_range(255)), n);
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    mode          = bswr_pkg::MODE_PUSH;
    value         = '0;
    count         = '0;
    cfg_valid     = 1'b0;
    capacity      = '0;
    calm          = 1'b0;
    hold_requests = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty stack corners, then pushes with dup, peek, rotations and print
    send_cmd(bswr_pkg::MODE_POP, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_PEEK, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_DUP, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_PRINT, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_ROT_UP, 8'h00, 7'd1);
    send_cmd(bswr_pkg::MODE_ROT_DOWN, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_PUSH, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_PUSH, 8'hFF, 7'd0);
    send_cmd(bswr_pkg::MODE_PUSH, 8'h5A, 7'd0);
    send_cmd(bswr_pkg::MODE_DUP, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_PEEK, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_ROT_UP, 8'h00, 7'd3);
    send_cmd(bswr_pkg::MODE_PRINT, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_ROT_DOWN, 8'h00, 7'd3);
    send_cmd(bswr_pkg::MODE_ROT_UP, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_ROT_DOWN, 8'h00, 7'd5);
    send_cmd(bswr_pkg::MODE_ROT_UP, 8'h00, 7'd127);
    send_cmd(MODE_UNUSED, 8'hFF, 7'd127);
    send_cmd(bswr_pkg::MODE_PRINT, 8'h00, 7'd0);
    // capacity below fill
    write_capacity(7'd2);
    send_cmd(bswr_pkg::MODE_PUSH, 8'h33, 7'd0);
    send_cmd(bswr_pkg::MODE_DUP, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_POP, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_ROT_DOWN, 8'h00, 7'd3);
    write_capacity(7'd0);
    send_cmd(bswr_pkg::MODE_PUSH, 8'hC3, 7'd0);

    // fill to the top, then full-depth rotations and a full print
    write_capacity(7'd64);
    calm = 1'b1;
    repeat (66) send_cmd(bswr_pkg::MODE_PUSH, bswr_pkg::DW'($urandom_range(255)), 7'd0);
    send_cmd(bswr_pkg::MODE_ROT_UP, 8'h00, 7'd64);
    send_cmd(bswr_pkg::MODE_ROT_DOWN, 8'h00, 7'd64);
    send_cmd(bswr_pkg::MODE_ROT_UP, 8'h00, 7'd65);
    send_cmd(bswr_pkg::MODE_PRINT, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_DUP, 8'h00, 7'd0);
    send_cmd(bswr_pkg::MODE_PEEK, 8'h00, 7'd0);
    calm = 1'b0;

    // receiver holds off while commands keep coming
    write_capacity(7'd127);
    hold_requests++;
    run_random(40, 25);
    write_capacity(7'd1);
    run_random(30, 40);
    write_capacity(7'd17);
    run_random(40, 55);
    write_capacity(7'd0);
    run_random(25, 40);
    write_capacity(bswr_pkg::CW'($urandom_range(1, 64)));
    run_random(40, 50);
    write_capacity(7'd100);
    run_random(10, 45);

    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_left == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bswr_pkg.sv
rtl/core/bswr_ram.sv
rtl/core/bswr_seq.sv
rtl/core/byte_stack_with_rotate.sv
rtl/core/bswr_chk.sv
tb/byte_stack_with_rotate_checker.sv
tb/byte_stack_with_rotate_test.sv
